/* rtl/rgsr_pkg.sv */
// Shared types and constants for the run-length glyph span renderer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rgsr_pkg;

    // Default geometry of one glyph and the pen step per character.
    localparam int DEF_GLYPH_SIDE  = 64;
    localparam int DEF_PEN_ADVANCE = 40;

    // Field widths.
    localparam int ADDR_W   = 24;
    localparam int COORD_W  = 16;
    localparam int LINE_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int COLOR_W  = 16;
    localparam int INDEX_W  = 16;
    localparam int STRIDE_W = 14;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GLYPH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_STARTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DRAWN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SKIPPED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SPAN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GAP     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVERRUN = 3'd5;

    // Configuration register indexes.
    localparam logic REG_LINE_STRIDE = 1'b0;
    localparam logic REG_FILL_COLOR  = 1'b1;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd2048;
    localparam logic [COLOR_W-1:0]  COLOR_RESET  = 16'hFFFF;

    // Glyph visibility window and the character that never draws.
    localparam logic signed [COORD_W-1:0] PEN_X_MIN  = -16'sd64;
    localparam logic signed [COORD_W-1:0] PEN_X_MAX  = 16'sd320;
    localparam logic [BYTE_W-1:0]         SPACE_CHAR = 8'd32;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // A classified input word as it travels from front to back end.
    typedef struct packed {
        logic [CMD_W-1:0]          op;
        logic signed [COORD_W-1:0] coord_x;
        logic [LINE_W-1:0]         coord_y;
        logic                      is_space;
        logic [BYTE_W-1:0]         run_length;
    } fe_item_t;

endpackage

`default_nettype wire

/* rtl/rgsr_front.sv */
// Front end: accepts input words, drops reserved commands and classifies
// the rest into one register stage. Depends on rgsr_pkg.
`default_nettype none

module rgsr_front
    import rgsr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [CMD_W-1:0]     s_axis_tuser,
    output logic                      push,
    output fe_item_t                  push_item,
    input  wire logic                 q_ready
);

    logic     fe_valid_reg;
    logic     fe_valid_next;
    fe_item_t fe_item_reg;
    fe_item_t fe_item_next;
    logic     accept;

    assign s_axis_tready = !fe_valid_reg || q_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = fe_valid_reg && q_ready;
    assign push_item     = fe_item_reg;

    always_comb
    begin
        fe_item_next.op         = s_axis_tuser;
        fe_item_next.coord_x    = s_axis_tdata[15:0];
        fe_item_next.coord_y    = s_axis_tdata[25:16];
        fe_item_next.is_space   = (s_axis_tdata[33:26] == SPACE_CHAR);
        fe_item_next.run_length = s_axis_tdata[41:34];
    end

    always_comb
    begin
        fe_valid_next = fe_valid_reg;
        if (accept)
        begin
            // Reserved commands have no effect and are not passed on.
            fe_valid_next = (s_axis_tuser != CMD_RSVD);
        end
        else if (push)
        begin
            fe_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else
        begin
            fe_valid_reg <= fe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fe_item_reg <= fe_item_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/rgsr_queue.sv */
// Short queue that decouples the front end from the back end.
// Depends on rgsr_pkg for the item type and the depth.
`default_nettype none

module rgsr_queue
    import rgsr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  fe_item_t      push_item,
    output logic          q_ready,
    output logic          q_valid,
    output fe_item_t      q_item,
    input  wire logic     pop
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fe_item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign q_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The front end only writes when there is room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(QUEUE_DEPTH)) || pop)
        else $error("queue written while full");

    // The back end only reads when a word is waiting.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

/* rtl/rgsr_back.sv */
// Back end: holds pen, glyph and run state, executes one queued word per
// cycle unless the registered result channel it drives stalls. Depends on rgsr_pkg.
`default_nettype none

module rgsr_back
    import rgsr_pkg::*;
#(
    parameter int GLYPH_SIDE  = DEF_GLYPH_SIDE,
    parameter int PEN_ADVANCE = DEF_PEN_ADVANCE
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  fe_item_t                   q_item,
    output logic                       pop,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [COLOR_W-1:0]    cfg_data,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [KIND_W-1:0]          m_axis_tuser,
    output logic                       m_axis_tlast
);

    localparam int TOTAL = GLYPH_SIDE * GLYPH_SIDE;
    localparam int PIX_W = $clog2(TOTAL + 1);
    localparam int SUM_W = $clog2(TOTAL + 256);
    // Divisibility by the row length: x is a multiple of the side exactly
    // when the low LEM_F bits of x * ceil(2^LEM_F / side) are below that
    // constant, which holds for every x below 2^PIX_W.
    localparam int LEM_F = PIX_W + 8;
    localparam longint LEM_C = ((64'd1 << LEM_F) + GLYPH_SIDE - 1) / GLYPH_SIDE;
    localparam logic [LEM_F-1:0]         LEM_C_V  = LEM_F'(LEM_C);
    localparam logic [SUM_W-1:0]         TOTAL_S  = SUM_W'(TOTAL);
    localparam logic [ADDR_W-1:0]        SIDE_A   = ADDR_W'(GLYPH_SIDE);
    localparam logic signed [COORD_W:0]  ADVANCE  = (COORD_W+1)'(PEN_ADVANCE);
    localparam logic signed [COORD_W:0]  PEN_SAT  = 17'sd32767;

    // Configuration.
    logic [STRIDE_W-1:0]        stride_reg;
    logic [COLOR_W-1:0]         color_reg;

    // Rendering state.
    logic signed [COORD_W-1:0]  pen_x_reg,     pen_x_next;
    logic [LINE_W-1:0]          pen_y_reg,     pen_y_next;
    logic [INDEX_W-1:0]         glyph_cnt_reg, glyph_cnt_next;
    logic [ADDR_W-1:0]          wr_ptr_reg,    wr_ptr_next;
    logic [PIX_W-1:0]           pix_done_reg,  pix_done_next;
    logic                       solid_reg,     solid_next;
    logic                       active_reg,    active_next;
    logic signed [COORD_W-1:0]  cur_pen_reg,   cur_pen_next;
    logic [INDEX_W-1:0]         cur_idx_reg,   cur_idx_next;

    // Result register.
    logic                       out_valid_reg, out_valid_next;
    logic                       emit;
    logic [KIND_W-1:0]          kind_reg,      kind_next;
    logic [ADDR_W-1:0]          addr_reg,      addr_next;
    logic [BYTE_W-1:0]          len_reg,       len_next;
    logic [COLOR_W-1:0]         span_col_reg,  span_col_next;
    logic signed [COORD_W-1:0]  res_pen_reg,   res_pen_next;
    logic [INDEX_W-1:0]         res_idx_reg,   res_idx_next;
    logic                       done_reg,      done_next;

    // Datapath temporaries.
    logic [STRIDE_W-2:0]        half;
    logic [22:0]                line_base;
    logic [ADDR_W-1:0]          glyph_base;
    logic signed [COORD_W:0]    pen_adv;
    logic                       skip;
    logic [SUM_W-1:0]           pix_sum;
    logic [PIX_W+LEM_F-1:0]     lem_prod;
    logic                       row_end;
    logic [ADDR_W-1:0]          ptr_run;
    logic                       run_done;

    assign pop  = q_valid && (!out_valid_reg || m_axis_tready);
    assign half = stride_reg[STRIDE_W-1:1];

    assign line_base  = pen_y_reg * half;
    assign glyph_base = {1'b0, line_base}
                      + {{(ADDR_W-COORD_W){pen_x_reg[COORD_W-1]}}, pen_x_reg};
    assign pen_adv    = {pen_x_reg[COORD_W-1], pen_x_reg} + ADVANCE;
    assign skip       = q_item.is_space || (pen_x_reg < PEN_X_MIN)
                      || (pen_x_reg > PEN_X_MAX);

    assign pix_sum  = SUM_W'(pix_done_reg) + SUM_W'(q_item.run_length);
    assign lem_prod = {{LEM_F{1'b0}}, pix_sum[PIX_W-1:0]}
                    * {{PIX_W{1'b0}}, LEM_C_V};
    assign row_end  = (q_item.run_length != '0) && (lem_prod[LEM_F-1:0] < LEM_C_V);
    assign ptr_run  = wr_ptr_reg + ADDR_W'(q_item.run_length);
    assign run_done = (pix_sum == TOTAL_S);

    always_comb
    begin
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        glyph_cnt_next = glyph_cnt_reg;
        wr_ptr_next    = wr_ptr_reg;
        pix_done_next  = pix_done_reg;
        solid_next     = solid_reg;
        active_next    = active_reg;
        cur_pen_next   = cur_pen_reg;
        cur_idx_next   = cur_idx_reg;

        emit           = 1'b0;
        kind_next      = KIND_STARTED;
        addr_next      = '0;
        len_next       = '0;
        span_col_next  = '0;
        res_pen_next   = cur_pen_reg;
        res_idx_next   = cur_idx_reg;
        done_next      = 1'b0;

        if (pop)
        begin
            case (q_item.op)
                CMD_START:
                begin
                    pen_x_next     = q_item.coord_x;
                    pen_y_next     = q_item.coord_y;
                    glyph_cnt_next = '0;
                    active_next    = 1'b0;
                    emit           = 1'b1;
                    kind_next      = KIND_STARTED;
                    res_pen_next   = q_item.coord_x;
                    res_idx_next   = '0;
                end
                CMD_GLYPH:
                begin
                    pen_x_next     = (pen_adv > PEN_SAT) ? PEN_SAT[COORD_W-1:0]
                                                         : pen_adv[COORD_W-1:0];
                    glyph_cnt_next = glyph_cnt_reg + 1'b1;
                    emit           = 1'b1;
                    res_pen_next   = pen_x_reg;
                    res_idx_next   = glyph_cnt_reg;
                    if (skip)
                    begin
                        active_next = 1'b0;
                        kind_next   = KIND_SKIPPED;
                    end
                    else
                    begin
                        wr_ptr_next   = glyph_base;
                        pix_done_next = '0;
                        solid_next    = 1'b0;
                        active_next   = 1'b1;
                        cur_pen_next  = pen_x_reg;
                        cur_idx_next  = glyph_cnt_reg;
                        kind_next     = KIND_DRAWN;
                        addr_next     = glyph_base;
                    end
                end
                CMD_RUN:
                begin
                    // A run with no open glyph is consumed silently.
                    if (active_reg)
                    begin
                        emit      = 1'b1;
                        addr_next = wr_ptr_reg;
                        len_next  = q_item.run_length;
                        if (pix_sum > TOTAL_S)
                        begin
                            active_next = 1'b0;
                            kind_next   = KIND_OVERRUN;
                        end
                        else
                        begin
                            pix_done_next = pix_sum[PIX_W-1:0];
                            solid_next    = !solid_reg;
                            wr_ptr_next   = ptr_run;
                            if (row_end)
                            begin
                                wr_ptr_next = ptr_run + ADDR_W'(half) - SIDE_A;
                                solid_next  = 1'b0;
                            end
                            if (run_done)
                            begin
                                active_next = 1'b0;
                            end
                            done_next = run_done;
                            if (solid_reg)
                            begin
                                kind_next     = KIND_SPAN;
                                span_col_next = color_reg;
                            end
                            else
                            begin
                                kind_next = KIND_GAP;
                            end
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg    <= STRIDE_RESET;
            color_reg     <= COLOR_RESET;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            glyph_cnt_reg <= '0;
            wr_ptr_reg    <= '0;
            pix_done_reg  <= '0;
            solid_reg     <= 1'b0;
            active_reg    <= 1'b0;
            cur_pen_reg   <= '0;
            cur_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_LINE_STRIDE))
            begin
                stride_reg <= cfg_data[STRIDE_W-1:0];
            end
            if (cfg_we && (cfg_index == REG_FILL_COLOR))
            begin
                color_reg <= cfg_data;
            end
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            glyph_cnt_reg <= glyph_cnt_next;
            wr_ptr_reg    <= wr_ptr_next;
            pix_done_reg  <= pix_done_next;
            solid_reg     <= solid_next;
            active_reg    <= active_next;
            cur_pen_reg   <= cur_pen_next;
            cur_idx_reg   <= cur_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg     <= kind_next;
            addr_reg     <= addr_next;
            len_reg      <= len_next;
            span_col_reg <= span_col_next;
            res_pen_reg  <= res_pen_next;
            res_idx_reg  <= res_idx_next;
            done_reg     <= done_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = done_reg;
    assign m_axis_tdata  = {res_idx_reg, res_pen_reg, span_col_reg, len_reg, addr_reg};

    a_pix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pix_done_reg <= PIX_W'(TOTAL))
        else $error("pixel count past glyph size");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (kind_reg == KIND_SPAN || kind_reg == KIND_GAP))
        else $error("glyph end flagged on a word that is not a run");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit && done_next) |=> !active_reg)
        else $error("glyph still open after its last run");

    a_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_STARTED) |-> (res_idx_reg == '0 && addr_reg == '0))
        else $error("start word with nonzero index or address");

endmodule

`default_nettype wire

/* rtl/rle_glyph_span_renderer.sv */
// Run-length glyph span renderer, top level.
// Input words (s_axis) carry start, glyph and run commands; tuser holds the
// command. Result words (m_axis) report starts, drawn or skipped glyphs,
// spans, gaps and overruns; tuser holds the kind and tlast marks the run
// that completes a glyph.
// Configuration: cfg_we writes cfg_data into register cfg_index (0: line stride
// in bytes, 1: fill colour) on the clock edge; the user must write only while idle,
// and the block itself does not enforce it. Throughput is one word per cycle
// while the receiver keeps up: the front register, a two-entry queue and the
// back end each move one word per cycle, and the back end executes each
// command as it pops it. An input word is held in the front register, then
// in a queue slot, and its result word is registered in the result register.
// Reserved commands and runs outside an open glyph give no result word.
// A stalled receiver holds the result register; the queue then fills and
// s_axis_tready falls after at most three further non-reserved words.
// Reset (rst_n low) clears pen, glyph ordinal and run state, closes any
// open glyph, sets the stride to 2048 and the colour to all ones.
`default_nettype none

module rle_glyph_span_renderer
    import rgsr_pkg::*;
#(
    parameter int GLYPH_SIDE  = DEF_GLYPH_SIDE,
    parameter int PEN_ADVANCE = DEF_PEN_ADVANCE
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // coord_x[15:0], coord_y[25:16], char_byte[33:26], run_length[41:34]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  wire logic [CMD_W-1:0]      s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // span_address[23:0], span_length[31:24], span_color[47:32],
    // pen_x[63:48], glyph_index[79:64]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // kind[2:0]
    output logic [KIND_W-1:0]          m_axis_tuser,
    // glyph_done
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [COLOR_W-1:0]    cfg_data
);

    logic     push;
    fe_item_t push_item;
    logic     q_ready;
    logic     q_valid;
    fe_item_t q_item;
    logic     pop;

    rgsr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_item     (push_item),
        .q_ready       (q_ready)
    );

    rgsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    rgsr_back #(
        .GLYPH_SIDE  (GLYPH_SIDE),
        .PEN_ADVANCE (PEN_ADVANCE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_rle_glyph_span_renderer.sv */
// Self-checking testbench for the run-length glyph span renderer.
// It drives start, glyph, run and reserved words, predicts every result word and compares them.
// Depends on rgsr_pkg and rle_glyph_span_renderer only.
`timescale 1ns / 100ps

module tb_rle_glyph_span_renderer;
    import rgsr_pkg::*;

    localparam int GLYPH_PIXELS = DEF_GLYPH_SIDE * DEF_GLYPH_SIDE;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 50;
    localparam int SKIP_WORDS   = 200;
    localparam int PHASE_WORDS  = 260;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  len;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] pen;
        logic [INDEX_W-1:0] idx;
        logic               done;
    } span_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = CMD_START;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_LINE_STRIDE;
    logic [COLOR_W-1:0]    cfg_data = '0;

    // Predictor state.
    int                    pen_x_q;
    logic [LINE_W-1:0]     pen_y_q;
    logic [INDEX_W-1:0]    ordinal_q;
    logic [ADDR_W-1:0]     wr_ptr_q;
    int                    pix_done_q;
    bit                    solid_q;
    bit                    glyph_open_q;
    logic [COORD_W-1:0]    open_pen_q;
    logic [INDEX_W-1:0]    open_idx_q;
    logic [STRIDE_W-1:0]   stride_q;
    logic [COLOR_W-1:0]    color_q;

    span_word_t            expected_words[$];
    span_word_t            want_w;
    span_word_t            got_w;
    int                    results_predicted = 0;
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    int                    hold_left = 0;
    bit                    tx_idle_en = 1'b1;
    bit                    rx_idle_en = 1'b1;

    rle_glyph_span_renderer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Computes the result word of one accepted input word and advances the pen,
    // glyph and run state. Returns 0 when the word yields no result.
    function automatic bit render_step(input logic [CMD_W-1:0] cmd,
                                       input logic [COORD_W-1:0] x,
                                       input logic [LINE_W-1:0] y,
                                       input logic [BYTE_W-1:0] ch,
                                       input logic [BYTE_W-1:0] len,
                                       output span_word_t w);
        int          px;
        int          nx;
        bit          skip;
        logic [12:0] half;
        logic [31:0] base;
        logic [ADDR_W-1:0] start;
        bit          was_solid;
        w = '0;
        half = stride_q[STRIDE_W-1:1];
        case (cmd)
            CMD_START:
            begin
                pen_x_q = $signed(x);
                pen_y_q = y;
                ordinal_q = '0;
                glyph_open_q = 1'b0;
                w.kind = KIND_STARTED;
                w.pen = x;
                return 1'b1;
            end
            CMD_GLYPH:
            begin
                px = pen_x_q;
                skip = (ch == SPACE_CHAR) || (px < PEN_X_MIN) || (px > PEN_X_MAX);
                nx = px + DEF_PEN_ADVANCE;
                pen_x_q = (nx > 32767) ? 32767 : nx;
                w.pen = px[COORD_W-1:0];
                w.idx = ordinal_q;
                ordinal_q = ordinal_q + 1'b1;
                if (skip)
                begin
                    glyph_open_q = 1'b0;
                    w.kind = KIND_SKIPPED;
                    return 1'b1;
                end
                base = 32'(pen_y_q) * 32'(half) + 32'(px);
                wr_ptr_q = base[ADDR_W-1:0];
                pix_done_q = 0;
                solid_q = 1'b0;
                glyph_open_q = 1'b1;
                open_pen_q = w.pen;
                open_idx_q = w.idx;
                w.kind = KIND_DRAWN;
                w.addr = wr_ptr_q;
                return 1'b1;
            end
            CMD_RUN:
            begin
                if (!glyph_open_q)
                    return 1'b0;
                start = wr_ptr_q;
                was_solid = solid_q;
                w.addr = start;
                w.len = len;
                w.pen = open_pen_q;
                w.idx = open_idx_q;
                if (pix_done_q + int'(len) > GLYPH_PIXELS)
                begin
                    glyph_open_q = 1'b0;
                    w.kind = KIND_OVERRUN;
                    return 1'b1;
                end
                pix_done_q = pix_done_q + int'(len);
                wr_ptr_q = wr_ptr_q + ADDR_W'(len);
                solid_q = !solid_q;
                // Only a nonzero run that lands exactly on a row end steps a line.
                if (len != 0 && (pix_done_q % DEF_GLYPH_SIDE) == 0)
                begin
                    wr_ptr_q = wr_ptr_q + ADDR_W'(half) - ADDR_W'(DEF_GLYPH_SIDE);
                    solid_q = 1'b0;
                end
                if (pix_done_q == GLYPH_PIXELS)
                begin
                    w.done = 1'b1;
                    glyph_open_q = 1'b0;
                end
                w.kind = was_solid ? KIND_SPAN : KIND_GAP;
                w.color = was_solid ? color_q : '0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $time);
    endtask

    // Sends one input word, with a random gap in front of it, and records the
    // expected result once the word is accepted.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] x,
                             input logic [LINE_W-1:0] y, input logic [BYTE_W-1:0] ch,
                             input logic [BYTE_W-1:0] len);
        span_word_t w;
        if (tx_idle_en && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'b0, len, ch, y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (render_step(cmd, x, y, ch, len, w))
        begin
            expected_words.push_back(w);
            results_predicted++;
        end
    endtask

    // Register writes wait until the block has drained.
    task automatic write_reg(input logic idx, input logic [COLOR_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LINE_STRIDE)
            stride_q = value[STRIDE_W-1:0];
        else
            color_q = value;
    endtask

    task automatic test_directed_basics();
        send_word(CMD_RSVD, 16'hFFFF, 10'h3FF, 8'hFF, 8'hFF);
        send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd255);
        send_word(CMD_START, 16'h8000, 10'd1023, 8'h0, 8'h0);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'h41, 8'h0);
        // Left edge on line 0: the glyph address wraps below zero.
        send_word(CMD_START, 16'hFFC0, 10'd0, 8'h0, 8'h0);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'hFF, 8'h0);
        send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd0);
        send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd0);
        send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd64);
        send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd255);
        send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd1);
        send_word(CMD_GLYPH, 16'h0, 10'h0, SPACE_CHAR, 8'h0);
        send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd5);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'h00, 8'h0);
        send_word(CMD_START, 16'd320, 10'd1023, 8'h0, 8'h0);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'h42, 8'h0);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'h43, 8'h0);
        send_word(CMD_START, 16'd32760, 10'd5, 8'h0, 8'h0);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'h44, 8'h0);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'h45, 8'h0);
        send_word(CMD_START, 16'hFFBF, 10'd5, 8'h0, 8'h0);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'h46, 8'h0);
    endtask

    // Runs of 255 do not end rows; the last run of 16 closes the glyph.
    task automatic test_glyph_completion();
        int i;
        send_word(CMD_START, 16'd100, 10'd7, 8'h0, 8'h0);
        send_word(CMD_GLYPH, 16'h0, 10'h0, 8'h57, 8'h0);
        for (i = 0; i < 16; i++)
            send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd255);
        send_word(CMD_RUN, 16'h0, 10'h0, 8'h0, 8'd16);
    endtask

    // The pen starts right of the visible window, so every glyph is skipped
    // while the ordinal counts up and the pen runs into saturation.
    task automatic test_skipped_glyphs();
        int i;
        send_word(CMD_START, 16'd32000, 10'd0, 8'h0, 8'h0);
        for (i = 1; i < SKIP_WORDS; i++)
            send_word(CMD_GLYPH, 16'($urandom), 10'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_traffic(input int quota);
        int target;
        int pick;
        int remaining;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] ch;
        logic [COORD_W-1:0] x;
        target = results_predicted + quota;
        while (results_predicted < target)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_word(CMD_W'($urandom_range(3)), 16'($urandom), 10'($urandom),
                          8'($urandom), 8'($urandom));
            else if (pick < 22)
            begin
                x = ($urandom_range(3) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 480) - 100);
                send_word(CMD_START, x, 10'($urandom), 8'($urandom), 8'($urandom));
            end
            else
            begin
                ch = ($urandom_range(7) == 0) ? SPACE_CHAR : 8'($urandom);
                send_word(CMD_GLYPH, 16'($urandom), 10'($urandom), ch, 8'($urandom));
                while (glyph_open_q)
                begin
                    remaining = GLYPH_PIXELS - pix_done_q;
                    pick = $urandom_range(99);
                    if (pick < 2)
                        break;
                    if (remaining <= 255 && pick < 60)
                        len = (remaining < 255 && pick >= 42)
                              ? 8'($urandom_range(remaining + 1, 255)) : 8'(remaining);
                    else if (pick < 80)
                        len = 8'(16 * $urandom_range(0, 15));
                    else
                        len = 8'($urandom);
                    send_word(CMD_RUN, 16'($urandom), 10'($urandom), 8'($urandom), len);
                end
            end
        end
    endtask

    // The receiver holds off long enough for the block to back up its input.
    task automatic test_backpressure();
        hold_left = 400;
        random_traffic(60);
    endtask

    task automatic test_random_renders();
        random_traffic(PHASE_WORDS);
        write_reg(REG_LINE_STRIDE, 16'd2);
        write_reg(REG_FILL_COLOR, 16'h0000);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_traffic(PHASE_WORDS);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        write_reg(REG_LINE_STRIDE, 16'd8192);
        write_reg(REG_FILL_COLOR, 16'hFFFF);
        random_traffic(PHASE_WORDS);
        // An odd stride: the low bit must be ignored.
        write_reg(REG_LINE_STRIDE, 16'd1025);
        write_reg(REG_FILL_COLOR, 16'($urandom));
        random_traffic(PHASE_WORDS);
        write_reg(REG_LINE_STRIDE, {2'($urandom), 14'($urandom_range(2, 8192))});
        write_reg(REG_FILL_COLOR, 16'($urandom));
        random_traffic(PHASE_WORDS);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= !rx_idle_en || ($urandom_range(99) >= 12);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_w.kind  = m_axis_tuser;
            got_w.addr  = m_axis_tdata[23:0];
            got_w.len   = m_axis_tdata[31:24];
            got_w.color = m_axis_tdata[47:32];
            got_w.pen   = m_axis_tdata[63:48];
            got_w.idx   = m_axis_tdata[79:64];
            got_w.done  = m_axis_tlast;
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, kind", '0, 32'(got_w.kind));
            else
            begin
                want_w = expected_words.pop_front();
                if (got_w.kind != want_w.kind)
                    report_mismatch("kind", 32'(want_w.kind), 32'(got_w.kind));
                if (got_w.addr != want_w.addr)
                    report_mismatch("span_address", 32'(want_w.addr), 32'(got_w.addr));
                if (got_w.len != want_w.len)
                    report_mismatch("span_length", 32'(want_w.len), 32'(got_w.len));
                if (got_w.color != want_w.color)
                    report_mismatch("span_color", 32'(want_w.color), 32'(got_w.color));
                if (got_w.pen != want_w.pen)
                    report_mismatch("pen_x", 32'(want_w.pen), 32'(got_w.pen));
                if (got_w.idx != want_w.idx)
                    report_mismatch("glyph_index", 32'(want_w.idx), 32'(got_w.idx));
                if (got_w.done != want_w.done)
                    report_mismatch("glyph_done", 32'(want_w.done), 32'(got_w.done));
            end
        end
    end

    // Ends a hung run: no word moving on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        pen_x_q = 0;
        pen_y_q = '0;
        ordinal_q = '0;
        wr_ptr_q = '0;
        pix_done_q = 0;
        solid_q = 1'b0;
        glyph_open_q = 1'b0;
        open_pen_q = '0;
        open_idx_q = '0;
        stride_q = STRIDE_RESET;
        color_q = COLOR_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_glyph_completion();
        test_skipped_glyphs();
        test_backpressure();
        test_random_renders();

        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
